// ===== rtl/iva_pkg.sv =====
// ----------------------------------------------------------------------------
// iva_pkg
// Types, codes and helper functions shared by the interrupt vector allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package iva_pkg;

  localparam int unsigned MapWordW = 64;

  // Request kinds
  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_SPACE    = 2'd1,
    STAT_UNSUPPORTED = 2'd2,
    STAT_INVALID     = 2'd3
  } status_e;

  // Handler actions reported with a result
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_INSTALL = 2'd1,
    ACT_CLEAR   = 2'd2
  } action_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RANGE_BASE      = 2'd0,
    CFG_RANGE_TOP       = 2'd1,
    CFG_RESERVED_VECTOR = 2'd2
  } cfg_index_e;

  // What a captured request still needs after the capture cycle
  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_INIT = 2'd1,
    KIND_SCAN = 2'd2
  } kind_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_INIT = 2'd1,
    ST_SCAN = 2'd2,
    ST_DONE = 2'd3
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic init_step;
    logic scan_step;
    logic push_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  last_word;
    logic  found;
  } stat_t;

  // Bits of one map word whose vectors lie in [base, top]
  function automatic logic [MapWordW-1:0] range_mask(logic [7:0] base, logic [7:0] top,
                                                     logic [1:0] word);
    logic [MapWordW-1:0] m;
    logic [7:0]          v;
    m = '0;
    for (int i = 0; i < MapWordW; i++) begin
      v    = {word, 6'(i)};
      m[i] = (v >= base) && (v <= top);
    end
    return m;
  endfunction

  // Index of the lowest set bit of a map word
  function automatic logic [5:0] first_set(logic [MapWordW-1:0] w);
    logic [5:0] pos;
    pos = '0;
    for (int i = MapWordW - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = 6'(i);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/iva_ctrl.sv =====
// ----------------------------------------------------------------------------
// iva_ctrl
// Controller: sequences capture, map initialisation, the free-vector scan
// and the hand-over of each result word to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module iva_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire iva_pkg::stat_t stat_i,
  output iva_pkg::cmd_t      cmd_o
);

  iva_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iva_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      iva_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (stat_i.kind)
            iva_pkg::KIND_INIT: state_d = iva_pkg::ST_INIT;
            iva_pkg::KIND_SCAN: state_d = iva_pkg::ST_SCAN;
            default:            state_d = iva_pkg::ST_DONE;
          endcase
        end
      end
      iva_pkg::ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (stat_i.last_word) begin
          state_d = iva_pkg::ST_DONE;
        end
      end
      iva_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.found || stat_i.last_word) begin
          state_d = iva_pkg::ST_DONE;
        end
      end
      iva_pkg::ST_DONE: begin
        // hand over once the output register is empty or being drained
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.push_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = iva_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = iva_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != iva_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/iva_dp.sv =====
// ----------------------------------------------------------------------------
// iva_dp
// Datapath: configuration registers, in-use map words, request checks,
// one-word-per-cycle init and first-free scan, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module iva_dp #(
  parameter int unsigned NUM_VECTORS = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [7:0]     cfg_wdata_i,
  input  wire logic [1:0]     op_i,
  input  wire logic [7:0]     cpu_index_i,
  input  wire logic [7:0]     want_count_i,
  input  wire logic           handler_given_i,
  input  wire logic [7:0]     free_vector_i,
  input  wire iva_pkg::cmd_t  cmd_i,
  output iva_pkg::stat_t      stat_o,
  output logic [1:0]          status_o,
  output logic [7:0]          vector_o,
  output logic [1:0]          handler_action_o
);

  localparam int unsigned WordW = iva_pkg::MapWordW;
  localparam int unsigned Words = (NUM_VECTORS + WordW - 1) / WordW;
  localparam int unsigned CntW  = (Words > 1) ? $clog2(Words) : 1;

  logic [7:0]       range_base_q, range_top_q, reserved_q;
  logic [WordW-1:0] map_q [Words];
  logic             ready_q;
  logic [CntW-1:0]  cnt_q;

  iva_pkg::status_e res_status_q, out_status_q;
  logic [7:0]       res_vector_q, out_vector_q;
  iva_pkg::action_e res_action_q, out_action_q;

  logic [1:0]       word_idx;
  logic [WordW-1:0] cur_word, inrange, exist, cand, res_bit, init_word;
  logic [5:0]       pos;
  logic             found, last_word;

  iva_pkg::kind_e   kind;
  iva_pkg::status_e imm_status;
  logic [7:0]       imm_vector;
  iva_pkg::action_e imm_action;
  logic             do_free;

  // Vectors of a word that exist below NUM_VECTORS
  function automatic logic [WordW-1:0] exist_mask(logic [1:0] word);
    logic [WordW-1:0] m;
    m = '0;
    for (int i = 0; i < WordW; i++) begin
      m[i] = ({1'b0, word, 6'(i)} < 9'(NUM_VECTORS));
    end
    return m;
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_base_q <= 8'd32;
      range_top_q  <= 8'd239;
      reserved_q   <= 8'd236;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        iva_pkg::CFG_RANGE_BASE:      range_base_q <= cfg_wdata_i;
        iva_pkg::CFG_RANGE_TOP:       range_top_q  <= cfg_wdata_i;
        iva_pkg::CFG_RESERVED_VECTOR: reserved_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Current map word and what the scan and init make of it
  assign word_idx  = 2'(cnt_q);
  assign last_word = (cnt_q == CntW'(Words - 1));
  assign cur_word  = map_q[cnt_q];
  assign inrange   = iva_pkg::range_mask(range_base_q, range_top_q, word_idx);
  assign exist     = exist_mask(word_idx);
  assign cand      = ~cur_word & inrange & exist;
  assign found     = |cand;
  assign pos       = iva_pkg::first_set(cand);
  assign res_bit   = (reserved_q[7:6] == word_idx) ? (WordW'(1) << reserved_q[5:0]) : '0;
  assign init_word = (~inrange | res_bit) & exist;

  // Request checks, in priority order
  always_comb begin
    kind       = iva_pkg::KIND_DONE;
    imm_status = iva_pkg::STAT_INVALID;
    imm_vector = 8'd0;
    imm_action = iva_pkg::ACT_NONE;
    do_free    = 1'b0;
    case (op_i)
      iva_pkg::OP_INIT: begin
        kind       = iva_pkg::KIND_INIT;
        imm_status = iva_pkg::STAT_OK;
      end
      iva_pkg::OP_ALLOC: begin
        if (cpu_index_i != 8'd0) begin
          imm_status = iva_pkg::STAT_UNSUPPORTED;
        end else if (want_count_i == 8'd0 || !handler_given_i) begin
          imm_status = iva_pkg::STAT_INVALID;
        end else if (want_count_i > 8'd1) begin
          imm_status = iva_pkg::STAT_UNSUPPORTED;
        end else if (!ready_q) begin
          imm_status = iva_pkg::STAT_INVALID;
        end else begin
          kind = iva_pkg::KIND_SCAN;
        end
      end
      iva_pkg::OP_FREE: begin
        if (cpu_index_i != 8'd0) begin
          imm_status = iva_pkg::STAT_UNSUPPORTED;
        end else if (free_vector_i < range_base_q || free_vector_i > range_top_q ||
                     free_vector_i == reserved_q ||
                     {1'b0, free_vector_i} >= 9'(NUM_VECTORS)) begin
          imm_status = iva_pkg::STAT_INVALID;
        end else begin
          imm_status = iva_pkg::STAT_OK;
          imm_vector = free_vector_i;
          imm_action = iva_pkg::ACT_CLEAR;
          do_free    = 1'b1;
        end
      end
      default: begin
        imm_status = iva_pkg::STAT_INVALID;
      end
    endcase
  end

  // Map, ready flag and word counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < Words; w++) begin
        map_q[w] <= '0;
      end
      ready_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.capture) begin
        cnt_q <= '0;
        if (do_free) begin
          map_q[free_vector_i[6 +: CntW]][free_vector_i[5:0]] <= 1'b0;
        end
      end else if (cmd_i.init_step) begin
        map_q[cnt_q] <= init_word;
        cnt_q        <= cnt_q + CntW'(1);
        if (last_word) begin
          ready_q <= 1'b1;
        end
      end else if (cmd_i.scan_step) begin
        if (found) begin
          map_q[cnt_q][pos] <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
    end
  end

  // Result word under construction, then the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_status_q <= imm_status;
      res_vector_q <= imm_vector;
      res_action_q <= imm_action;
    end else if (cmd_i.scan_step) begin
      if (found) begin
        res_status_q <= iva_pkg::STAT_OK;
        res_vector_q <= {word_idx, pos};
        res_action_q <= iva_pkg::ACT_INSTALL;
      end else if (last_word) begin
        res_status_q <= iva_pkg::STAT_NO_SPACE;
        res_vector_q <= 8'd0;
        res_action_q <= iva_pkg::ACT_NONE;
      end
    end
    if (cmd_i.push_out) begin
      out_status_q <= res_status_q;
      out_vector_q <= res_vector_q;
      out_action_q <= res_action_q;
    end
  end

  assign stat_o.kind      = kind;
  assign stat_o.last_word = last_word;
  assign stat_o.found     = found;

  assign status_o         = out_status_q;
  assign vector_o         = out_vector_q;
  assign handler_action_o = out_action_q;

endmodule

`default_nettype wire

// ===== rtl/interrupt_vector_allocator.sv =====
// ----------------------------------------------------------------------------
// interrupt_vector_allocator
// First-fit allocator of interrupt vectors over a bitmap of in-use vectors.
//
// Use: requests (init, allocate, free) enter on the input channel, one word
// per request, and each gives exactly one result word on the output channel.
// Configuration (range base, range top, reserved vector) is written through
// the plain write port while the block is idle.
// Flow: free, rejected and unknown requests go from accept to the done
// state and then to the output register; init first writes all W map
// words and an allocate that reaches the scan examines 1 to W of them,
// where W = ceil(NUM_VECTORS / 64): init writes and the scan examines one
// 64-bit map word per cycle. A new request is taken the cycle after the
// previous result is handed to the output register, not before.
// Reset: the map is cleared, the block is not ready (allocate is refused
// until an init) and the registers take their default values.
// A stalled output holds its word; a finished result waits in the datapath
// and the input stays stalled until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_vector_allocator #(
  parameter int unsigned NUM_VECTORS = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] cpu_index_i,
  input  wire logic [7:0] want_count_i,
  input  wire logic       handler_given_i,
  input  wire logic [7:0] free_vector_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      status_o,
  output logic [7:0]      vector_o,
  output logic [1:0]      handler_action_o
);

  iva_pkg::cmd_t  cmd;
  iva_pkg::stat_t stat;

  iva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  iva_dp #(
    .NUM_VECTORS (NUM_VECTORS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (op_i),
    .cpu_index_i      (cpu_index_i),
    .want_count_i     (want_count_i),
    .handler_given_i  (handler_given_i),
    .free_vector_i    (free_vector_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .status_o         (status_o),
    .vector_o         (vector_o),
    .handler_action_o (handler_action_o)
  );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interrupt vector allocator testbench
// Drives init, allocate and free requests through the valid/stall channel,
// predicts every result word from a local copy of the in-use map and the
// range registers, and compares each result word field by field. Register
// settings change between phases, including empty, inverted and full ranges.
// ----------------------------------------------------------------------------

module testbench;

  localparam int NumVectors = 256;
  localparam int HoldCycles = 300;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 60;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] cpu;
    logic [7:0] count;
    logic       handler;
    logic [7:0] fv;
  } request_t;

  typedef struct packed {
    iva_pkg::status_e status;
    logic [7:0]       vector;
    iva_pkg::action_e action;
  } outcome_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] op_i;
  logic [7:0] cpu_index_i;
  logic [7:0] want_count_i;
  logic       handler_given_i;
  logic [7:0] free_vector_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] status_o;
  logic [7:0] vector_o;
  logic [1:0] handler_action_o;

  // Local copy of the allocator state
  logic [NumVectors-1:0] model_busy = '0;
  logic                  model_ready = 1'b0;
  logic [7:0]            reg_base = 8'd32;
  logic [7:0]            reg_top = 8'd239;
  logic [7:0]            reg_reserved = 8'd236;

  outcome_t expected_outcomes[$];
  outcome_t due;

  int error_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int grant_count = 0;
  int no_space_count = 0;
  int settings_count = 0;
  int holds_done = 0;
  int cycle_count = 0;

  // Sender pacing and receiver stall pattern
  logic gaps_on = 1'b0;
  int   burst_left = 0;
  int   stall_mode = 0;
  logic hold_req = 1'b0;
  logic stall_on = 1'b0;
  int   stall_run_left = 0;

  interrupt_vector_allocator #(
    .NUM_VECTORS(NumVectors)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .cpu_index_i     (cpu_index_i),
    .want_count_i    (want_count_i),
    .handler_given_i (handler_given_i),
    .free_vector_i   (free_vector_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .vector_o        (vector_o),
    .handler_action_o(handler_action_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  // Receiver: long hold on request, otherwise by stall mode no stall or alternating runs of stall and free
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req    = 1'b0;
        out_stall_i = 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
        holds_done++;
      end else if (stall_mode == 0) begin
        out_stall_i = 1'b0;
      end else begin
        if (stall_run_left == 0) begin
          stall_on       = !stall_on;
          stall_run_left = stall_on ? $urandom_range(1, (stall_mode == 2) ? 6 : 2)
                                    : $urandom_range(1, (stall_mode == 2) ? 3 : 8);
        end
        stall_run_left--;
        out_stall_i = stall_on;
      end
    end
  end

  function automatic request_t make_request(logic [1:0] op, logic [7:0] cpu,
                                            logic [7:0] count, logic handler,
                                            logic [7:0] fv);
    request_t rq;
    rq.op      = op;
    rq.cpu     = cpu;
    rq.count   = count;
    rq.handler = handler;
    rq.fv      = fv;
    return rq;
  endfunction

  // Mostly well-formed allocate and free words, with some init and noise
  function automatic request_t random_request();
    request_t rq;
    int       pick;
    pick = $urandom_range(0, 99);
    rq   = make_request(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                        1'($urandom), 8'($urandom));
    if (pick < 4) begin
      rq.op = iva_pkg::OP_INIT;
    end else if (pick < 50) begin
      rq.op      = iva_pkg::OP_ALLOC;
      rq.cpu     = '0;
      rq.count   = 8'd1;
      rq.handler = 1'b1;
    end else if (pick < 78) begin
      rq.op  = iva_pkg::OP_FREE;
      rq.cpu = '0;
      rq.fv  = 8'($urandom_range(reg_base, reg_top));
    end else begin
      if ($urandom_range(0, 1) == 0) rq.cpu = '0;
      if ($urandom_range(0, 1) == 0) rq.count = 8'($urandom_range(0, 3));
    end
    return rq;
  endfunction

  task automatic predict_outcome(input request_t rq);
    outcome_t o;
    logic     found;
    o.status = iva_pkg::STAT_INVALID;
    o.vector = '0;
    o.action = iva_pkg::ACT_NONE;
    found    = 1'b0;
    case (rq.op)
      iva_pkg::OP_INIT: begin
        for (int v = 0; v < NumVectors; v++) begin
          model_busy[v] = (v < reg_base) || (v > reg_top);
        end
        model_busy[reg_reserved] = 1'b1;
        model_ready = 1'b1;
        o.status    = iva_pkg::STAT_OK;
      end
      iva_pkg::OP_ALLOC: begin
        if (rq.cpu != 0) begin
          o.status = iva_pkg::STAT_UNSUPPORTED;
        end else if (rq.count == 0 || !rq.handler) begin
          o.status = iva_pkg::STAT_INVALID;
        end else if (rq.count > 1) begin
          o.status = iva_pkg::STAT_UNSUPPORTED;
        end else if (!model_ready) begin
          o.status = iva_pkg::STAT_INVALID;
        end else begin
          for (int v = reg_base; v <= reg_top && v < NumVectors && !found; v++) begin
            if (!model_busy[v]) begin
              model_busy[v] = 1'b1;
              found    = 1'b1;
              o.status = iva_pkg::STAT_OK;
              o.vector = 8'(v);
              o.action = iva_pkg::ACT_INSTALL;
            end
          end
          if (found) begin
            grant_count++;
          end else begin
            o.status = iva_pkg::STAT_NO_SPACE;
            no_space_count++;
          end
        end
      end
      iva_pkg::OP_FREE: begin
        if (rq.cpu != 0) begin
          o.status = iva_pkg::STAT_UNSUPPORTED;
        end else if (rq.fv < reg_base || rq.fv > reg_top || rq.fv == reg_reserved) begin
          o.status = iva_pkg::STAT_INVALID;
        end else begin
          model_busy[rq.fv] = 1'b0;
          o.status = iva_pkg::STAT_OK;
          o.vector = rq.fv;
          o.action = iva_pkg::ACT_CLEAR;
        end
      end
      default: o.status = iva_pkg::STAT_INVALID;
    endcase
    expected_outcomes.push_back(o);
  endtask

  // Offer one word and hold it until accepted
  task automatic send_request(input request_t rq);
    @(negedge clk_i);
    op_i            = rq.op;
    cpu_index_i     = rq.cpu;
    want_count_i    = rq.count;
    handler_given_i = rq.handler;
    free_vector_i   = rq.fv;
    in_valid_i      = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_outcome(rq);
    requests_sent++;
  endtask

  task automatic send_paced(input request_t rq);
    if (gaps_on) begin
      if (burst_left == 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
    send_request(rq);
  endtask

  // Drop valid and wait until every result word is back
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_register(input iva_pkg::cfg_index_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      iva_pkg::CFG_RANGE_BASE:      reg_base = value;
      iva_pkg::CFG_RANGE_TOP:       reg_top = value;
      iva_pkg::CFG_RESERVED_VECTOR: reg_reserved = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [7:0] base, input logic [7:0] top,
                               input logic [7:0] reserved);
    settle();
    write_register(iva_pkg::CFG_RANGE_BASE, base);
    write_register(iva_pkg::CFG_RANGE_TOP, top);
    write_register(iva_pkg::CFG_RESERVED_VECTOR, reserved);
    settings_count++;
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result word: status %0d vector %0d action %0d",
                 $time, status_o, vector_o, handler_action_o);
        error_count++;
      end else begin
        due = expected_outcomes.pop_front();
        check_field("status", due.status, status_o);
        check_field("vector", due.vector, vector_o);
        check_field("handler action", due.action, handler_action_o);
        results_checked++;
      end
    end
  end

  // Allocate and free before any init, and the order of error checks
  task automatic test_not_ready();
    stall_mode = 1;
    send_request(make_request(iva_pkg::OP_ALLOC, 8'd255, 8'd0, 1'b0, 8'd0));
    send_request(make_request(iva_pkg::OP_ALLOC, 8'd0, 8'd0, 1'b1, 8'd0));
    send_request(make_request(iva_pkg::OP_ALLOC, 8'd0, 8'd2, 1'b0, 8'd0));
    send_request(make_request(iva_pkg::OP_ALLOC, 8'd0, 8'd255, 1'b1, 8'd255));
    send_request(make_request(iva_pkg::OP_ALLOC, 8'd0, 8'd1, 1'b1, 8'd0));
    send_request(make_request(iva_pkg::OP_FREE, 8'd0, 8'd0, 1'b0, 8'd100));
    send_request(make_request(iva_pkg::OP_FREE, 8'd1, 8'd0, 1'b0, 8'd100));
    send_request(make_request(OpUnused, 8'd255, 8'd255, 1'b1, 8'd255));
  endtask

  // First fit at reset settings, reuse of a freed vector, refused frees
  task automatic test_first_fit();
    send_request(make_request(iva_pkg::OP_INIT, 8'd7, 8'd0, 1'b0, 8'd0));
    repeat (3) send_request(make_request(iva_pkg::OP_ALLOC, 8'd0, 8'd1, 1'b1, 8'd0));
    send_request(make_request(iva_pkg::OP_FREE, 8'd0, 8'd0, 1'b0, 8'd33));
    send_request(make_request(iva_pkg::OP_ALLOC, 8'd0, 8'd1, 1'b1, 8'd0));
    send_request(make_request(iva_pkg::OP_FREE, 8'd0, 8'd0, 1'b0, 8'd236));
    send_request(make_request(iva_pkg::OP_FREE, 8'd0, 8'd0, 1'b0, 8'd31));
    send_request(make_request(iva_pkg::OP_FREE, 8'd0, 8'd0, 1'b0, 8'd240));
    send_request(make_request(iva_pkg::OP_FREE, 8'd0, 8'd0, 1'b0, 8'd0));
    send_request(make_request(iva_pkg::OP_FREE, 8'd0, 8'd0, 1'b0, 8'd255));
  endtask

  // Run a tiny range dry, then widen it without init: the map keeps its marks
  task automatic test_exhaustion();
    apply_setting(8'd10, 8'd12, 8'd11);
    send_request(make_request(iva_pkg::OP_INIT, 8'd0, 8'd0, 1'b0, 8'd0));
    repeat (3) send_request(make_request(iva_pkg::OP_ALLOC, 8'd0, 8'd1, 1'b1, 8'd0));
    apply_setting(8'd10, 8'd14, 8'd11);
    send_request(make_request(iva_pkg::OP_ALLOC, 8'd0, 8'd1, 1'b1, 8'd0));
  endtask

  // Hold the output off for a long stretch while words keep coming
  task automatic test_output_hold();
    apply_setting(8'd32, 8'd239, 8'd236);
    stall_mode = 0;
    gaps_on    = 1'b0;
    send_request(make_request(iva_pkg::OP_INIT, 8'd0, 8'd0, 1'b0, 8'd0));
    settle();
    hold_req = 1'b1;
    repeat (16) send_request(random_request());
    settle();
  endtask

  task automatic test_random_settings();
    logic [7:0] base;
    logic [7:0] top;
    logic [7:0] reserved;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin base = 8'd32;  top = 8'd239; reserved = 8'd236; end
        1: begin base = 8'd0;   top = 8'd255; reserved = 8'd255; end
        2: begin base = 8'd0;   top = 8'd255; reserved = 8'd0;   end
        3: begin base = 8'd10;  top = 8'd13;  reserved = 8'd11;  end
        4: begin base = 8'd100; top = 8'd100; reserved = 8'd100; end
        5: begin base = 8'd200; top = 8'd100; reserved = 8'd150; end
        6: begin base = 8'd250; top = 8'd255; reserved = 8'd252; end
        7: begin base = 8'd0;   top = 8'd7;   reserved = 8'd3;   end
        default: begin
          base     = 8'($urandom_range(0, 255));
          top      = 8'($urandom_range(0, 255));
          reserved = 8'($urandom_range(base, top));
        end
      endcase
      apply_setting(base, top, reserved);
      gaps_on    = (p % 3) != 0;
      stall_mode = p % 3;
      if ($urandom_range(0, 3) != 0) begin
        send_paced(make_request(iva_pkg::OP_INIT, 8'($urandom), 8'($urandom),
                                1'($urandom), 8'($urandom)));
      end
      repeat (PhaseItems) send_paced(random_request());
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    op_i            = '0;
    cpu_index_i     = '0;
    want_count_i    = '0;
    handler_given_i = 1'b0;
    free_vector_i   = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_not_ready();
    test_first_fit();
    test_exhaustion();
    test_output_hold();
    test_random_settings();

    settle();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests under %0d register settings, checked %0d results.",
             requests_sent, settings_count, results_checked);
    $display("Granted %0d vectors, refused %0d for lack of space, %0d long output holds.",
             grant_count, no_space_count, holds_done);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
